[design/tdmh_pkg.sv]
// Shared types and codes for the timer deadline min-heap.
// Used by tdmh_cmp and timer_deadline_min_heap_core; no dependencies.
`timescale 1ns / 1ps

package tdmh_pkg;

  localparam int DEADLINE_W = 48;
  localparam int IDENT_W    = 32;
  localparam int NEXT_ID_W  = 33;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_DEL   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
  localparam logic [1:0] STATUS_NO_IDS    = 2'd3;

  // Deadline sits above the id, so one unsigned compare orders by deadline
  // and breaks ties by the lower id.
  typedef struct packed {
    logic [DEADLINE_W-1:0] deadline;
    logic [IDENT_W-1:0]    ident;
  } heap_entry_t;

  localparam int ENTRY_W = $bits(heap_entry_t);

  typedef enum logic [1:0] {
    CMP_RD_X,
    CMP_RD_BEST,
    CMP_X_RD
  } cmp_sel_e;

endpackage

[design/tdmh_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the heap entries; no dependencies.
`timescale 1ns / 1ps

module tdmh_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/tdmh_cmp.sv]
// Shared heap-order compare unit with its operand selection.
// Depends on tdmh_pkg for the entry type and the operand select codes.
`timescale 1ns / 1ps

module tdmh_cmp (
  input  tdmh_pkg::cmp_sel_e    sel_i,
  input  tdmh_pkg::heap_entry_t rd_i,
  input  tdmh_pkg::heap_entry_t x_i,
  input  tdmh_pkg::heap_entry_t best_i,
  output logic                  earlier_o
);
  import tdmh_pkg::*;

  heap_entry_t op_a;
  heap_entry_t op_b;

  always_comb begin
    case (sel_i)
      CMP_RD_X: begin
        op_a = rd_i;
        op_b = x_i;
      end
      CMP_RD_BEST: begin
        op_a = rd_i;
        op_b = best_i;
      end
      CMP_X_RD: begin
        op_a = x_i;
        op_b = rd_i;
      end
      default: begin
        op_a = rd_i;
        op_b = x_i;
      end
    endcase
  end

  assign earlier_o = (op_a < op_b);

endmodule

[design/timer_deadline_min_heap_core.sv]
// Timer queue as a binary min-heap. Query reads the root; add sifts the new timer up level by
// level; delete scans the ids through the single RAM read port, then sifts the last entry, moved
// into the hole, down and, if it did not move down, up.
// One word is worked on at a time; a new word is taken once the previous result is
// registered, even while that result still waits at the output.
// Reset clears the entry count, the id counter and the handshake state; RAM is not cleared.
`timescale 1ns / 1ps

module timer_deadline_min_heap_core #(
  parameter int DEPTH = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         op_i,
  input  logic [tdmh_pkg::DEADLINE_W-1:0]    now_ms_i,
  input  logic [31:0]                        interval_ms_i,
  input  logic [tdmh_pkg::IDENT_W-1:0]       timer_id_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         status_o,
  output logic [tdmh_pkg::IDENT_W-1:0]       assigned_id_o,
  output logic [tdmh_pkg::DEADLINE_W-1:0]    deadline_ms_o,
  output logic                               heap_empty_o
);
  import tdmh_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = IW + 2;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;
  localparam logic [3:0] S_LAST = 4'd2;
  localparam logic [3:0] S_LOAD = 4'd3;
  localparam logic [3:0] S_SD_L = 4'd4;
  localparam logic [3:0] S_SD_R = 4'd5;
  localparam logic [3:0] S_SD_C = 4'd6;
  localparam logic [3:0] S_SU_R = 4'd7;
  localparam logic [3:0] S_SU_C = 4'd8;
  localparam logic [3:0] S_QRD  = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0]           state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [NEXT_ID_W-1:0] next_id_q, next_id_d;
  logic [CW-1:0]        scan_addr_q, scan_addr_d;
  logic [IW-1:0]        chk_q, chk_d;
  logic                 chk_vld_q, chk_vld_d;
  logic [IDENT_W-1:0]   want_q, want_d;
  logic [IW-1:0]        pos_q, pos_d;
  heap_entry_t          x_q, x_d;
  heap_entry_t          best_val_q, best_val_d;
  logic [IW-1:0]        best_idx_q, best_idx_d;
  logic                 best_child_q, best_child_d;
  logic                 moved_q, moved_d;

  logic [1:0]            res_status_q, res_status_d;
  logic [IDENT_W-1:0]    res_id_q, res_id_d;
  logic [DEADLINE_W-1:0] res_deadline_q, res_deadline_d;
  logic                  res_empty_q, res_empty_d;
  logic                  out_valid_q;
  logic                  out_load;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  heap_entry_t   ram_wdata;
  logic [IW-1:0] ram_raddr;
  heap_entry_t   ram_rdata;

  cmp_sel_e cmp_sel;
  logic     cmp_earlier;

  logic [LW-1:0]         left_idx;
  logic [LW-1:0]         right_idx;
  logic [LW-1:0]         count_w;
  logic                  left_ok;
  logic                  right_ok;
  logic [IW-1:0]         parent_idx;
  logic [DEADLINE_W:0]   sum_full;
  logic [DEADLINE_W-1:0] sum_sat;
  logic                  scan_issue;
  logic                  scan_hit;
  logic [CW-1:0]         count_dec;
  logic                  take_right;

  tdmh_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tdmh_cmp u_cmp (
    .sel_i     (cmp_sel),
    .rd_i      (ram_rdata),
    .x_i       (x_q),
    .best_i    (best_val_q),
    .earlier_o (cmp_earlier)
  );

  assign count_w    = LW'(count_q);
  assign left_idx   = {1'b0, pos_q, 1'b1};
  assign right_idx  = left_idx + LW'(1);
  assign left_ok    = (left_idx < count_w);
  assign right_ok   = (right_idx < count_w);
  assign parent_idx = IW'((pos_q - IW'(1)) >> 1);
  assign sum_full   = {1'b0, now_ms_i} + (DEADLINE_W + 1)'(interval_ms_i);
  assign sum_sat    = sum_full[DEADLINE_W] ? '1 : sum_full[DEADLINE_W-1:0];
  assign scan_issue = (scan_addr_q < count_q);
  assign scan_hit   = chk_vld_q && (ram_rdata.ident == want_q);
  assign count_dec  = count_q - CW'(1);
  assign take_right = right_ok && cmp_earlier;

  assign in_stall_o = (state_q != S_IDLE);
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d        = state_q;
    count_d        = count_q;
    next_id_d      = next_id_q;
    scan_addr_d    = scan_addr_q;
    chk_d          = chk_q;
    chk_vld_d      = chk_vld_q;
    want_d         = want_q;
    pos_d          = pos_q;
    x_d            = x_q;
    best_val_d     = best_val_q;
    best_idx_d     = best_idx_q;
    best_child_d   = best_child_q;
    moved_d        = moved_q;
    res_status_d   = res_status_q;
    res_id_d       = res_id_q;
    res_deadline_d = res_deadline_q;
    res_empty_d    = res_empty_q;
    ram_we         = 1'b0;
    ram_waddr      = pos_q;
    ram_wdata      = x_q;
    ram_raddr      = '0;
    cmp_sel        = CMP_RD_X;

    unique case (state_q)
      S_IDLE: begin
        // Slot 0 is read every idle cycle so a query has its data next cycle.
        if (in_valid_i) begin
          res_status_d   = STATUS_OK;
          res_id_d       = '0;
          res_deadline_d = '0;
          res_empty_d    = 1'b0;
          moved_d        = 1'b0;
          unique case (op_i)
            OP_ADD: begin
              if (count_q >= CW'(DEPTH)) begin
                res_status_d = STATUS_FULL;
                state_d      = S_DONE;
              end else if (next_id_q[NEXT_ID_W-1]) begin
                res_status_d = STATUS_NO_IDS;
                state_d      = S_DONE;
              end else begin
                x_d       = '{deadline: sum_sat, ident: next_id_q[IDENT_W-1:0]};
                res_id_d  = next_id_q[IDENT_W-1:0];
                next_id_d = next_id_q + NEXT_ID_W'(1);
                pos_d     = count_q[IW-1:0];
                count_d   = count_q + CW'(1);
                state_d   = S_SU_R;
              end
            end
            OP_DEL: begin
              want_d      = timer_id_i;
              scan_addr_d = '0;
              chk_vld_d   = 1'b0;
              if (count_q == '0) begin
                res_status_d = STATUS_NOT_FOUND;
                state_d      = S_DONE;
              end else begin
                state_d = S_SCAN;
              end
            end
            OP_QUERY: begin
              if (count_q == '0) begin
                res_deadline_d = '1;
                res_empty_d    = 1'b1;
                state_d        = S_DONE;
              end else begin
                state_d = S_QRD;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // One address issued per cycle; the id of the previous one is checked.
        ram_raddr   = scan_addr_q[IW-1:0];
        chk_vld_d   = scan_issue;
        chk_d       = scan_addr_q[IW-1:0];
        scan_addr_d = scan_issue ? scan_addr_q + CW'(1) : scan_addr_q;
        if (scan_hit) begin
          count_d = count_dec;
          pos_d   = chk_q;
          if (CW'(chk_q) < count_dec) begin
            state_d = S_LAST;
          end else begin
            state_d = S_DONE;
          end
        end else if (!scan_issue) begin
          res_status_d = STATUS_NOT_FOUND;
          state_d      = S_DONE;
        end
      end

      S_LAST: begin
        ram_raddr = count_q[IW-1:0];
        state_d   = S_LOAD;
      end

      S_LOAD: begin
        x_d     = ram_rdata;
        state_d = S_SD_L;
      end

      S_SD_L: begin
        if (left_ok) begin
          ram_raddr = left_idx[IW-1:0];
          state_d   = S_SD_R;
        end else if (moved_q) begin
          ram_we  = 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_SU_R;
        end
      end

      S_SD_R: begin
        cmp_sel   = CMP_RD_X;
        ram_raddr = right_idx[IW-1:0];
        if (cmp_earlier) begin
          best_val_d   = ram_rdata;
          best_idx_d   = left_idx[IW-1:0];
          best_child_d = 1'b1;
        end else begin
          best_val_d   = x_q;
          best_child_d = 1'b0;
        end
        state_d = S_SD_C;
      end

      S_SD_C: begin
        cmp_sel = CMP_RD_BEST;
        if (take_right || best_child_q) begin
          // The earlier child moves up into the hole; the moving timer goes on down.
          ram_we    = 1'b1;
          ram_wdata = take_right ? ram_rdata : best_val_q;
          pos_d     = take_right ? right_idx[IW-1:0] : best_idx_q;
          moved_d   = 1'b1;
          state_d   = S_SD_L;
        end else if (moved_q) begin
          ram_we  = 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_SU_R;
        end
      end

      S_SU_R: begin
        if (pos_q == '0) begin
          ram_we  = 1'b1;
          state_d = S_DONE;
        end else begin
          ram_raddr = parent_idx;
          state_d   = S_SU_C;
        end
      end

      S_SU_C: begin
        cmp_sel = CMP_X_RD;
        ram_we  = 1'b1;
        if (cmp_earlier) begin
          ram_wdata = ram_rdata;
          pos_d     = parent_idx;
          state_d   = S_SU_R;
        end else begin
          state_d = S_DONE;
        end
      end

      S_QRD: begin
        res_deadline_d = ram_rdata.deadline;
        state_d        = S_DONE;
      end

      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      next_id_q   <= '0;
      chk_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      next_id_q <= next_id_d;
      chk_vld_q <= chk_vld_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scan_addr_q    <= scan_addr_d;
    chk_q          <= chk_d;
    want_q         <= want_d;
    pos_q          <= pos_d;
    x_q            <= x_d;
    best_val_q     <= best_val_d;
    best_idx_q     <= best_idx_d;
    best_child_q   <= best_child_d;
    moved_q        <= moved_d;
    res_status_q   <= res_status_d;
    res_id_q       <= res_id_d;
    res_deadline_q <= res_deadline_d;
    res_empty_q    <= res_empty_d;
    if (out_load) begin
      status_o      <= res_status_q;
      assigned_id_o <= res_id_q;
      deadline_ms_o <= res_deadline_q;
      heap_empty_o  <= res_empty_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // The entry count never passes the heap size.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CW'(DEPTH))
    else $error("entry count above heap size");

  // Every heap write lands inside the occupied region.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (CW'(ram_waddr) < count_q))
    else $error("heap write outside occupied slots");

  // A result appears only from the completion state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_DONE))
    else $error("result raised outside completion");

  // The id counter never runs backward.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_id_q >= $past(next_id_q))
    else $error("id counter decreased");

  // The next word is taken only after the previous result has been registered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> in_stall_o)
    else $error("input taken while a result is pending");

endmodule
